>>> rtl/core/gf128_clmul_multiply_reduce_core_defines.svh
// ----------------------------------------------------------------------------
// gf128_clmul_multiply_reduce_core_defines
// Assertion macros for the GF(2^128) multiply core.
// ----------------------------------------------------------------------------
`ifndef GF128_CLMUL_MULTIPLY_REDUCE_CORE_DEFINES_SVH
`define GF128_CLMUL_MULTIPLY_REDUCE_CORE_DEFINES_SVH

// Assert a property on the rising clock, disabled in reset.
`define GCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the rising clock, always active.
`define GCM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants and carry-less helpers for the GF(2^128) multiply core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gcm_pkg;
    localparam int unsigned LaneW = 64;
    localparam logic [63:0] FoldConst = 64'hc200000000000000;
    // One cell consumes this many bits of each multiplier lane per cycle while the pipe advances.
    localparam int unsigned BitsPerCell = 8;
    localparam int unsigned NumCells = LaneW / BitsPerCell;

    typedef logic [63:0]  t_lane;
    typedef logic [127:0] t_wide;

    // Partial carry-less product of x by an 8-bit slice of y placed at offset.
    function automatic t_wide clmul_slice(input t_lane x, input logic [7:0] y,
                                          input logic [6:0] off);
        t_wide acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) acc = acc ^ ({64'd0, x} << (off + 7'(i)));
        end
        return acc;
    endfunction

    // Fold constant has bits 63,62,57 set: product is three shifts.
    function automatic t_wide clmul_fold(input t_lane x);
        return ({64'd0, x} << 63) ^ ({64'd0, x} << 62) ^ ({64'd0, x} << 57);
    endfunction
endpackage

>>> rtl/core/gcm_if.sv
// ----------------------------------------------------------------------------
// gcm_if
// Valid/ready channels: operand words in, reduced product words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gcm_in_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
    modport source (output valid, a_low, a_high, b_low, b_high, input ready);
    modport sink   (input valid, a_low, a_high, b_low, b_high, output ready);
endinterface

interface gcm_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] product_low;
    logic [63:0] product_high;
    modport source (output valid, product_low, product_high, input ready);
    modport sink   (input valid, product_low, product_high, output ready);
endinterface

>>> rtl/core/gf128_clmul_multiply_reduce_core.sv
// ----------------------------------------------------------------------------
// gf128_clmul_multiply_reduce_core
// GHASH-style GF(2^128) carry-less multiply with two-step folding reduction.
// ----------------------------------------------------------------------------
// Takes one operand pair per cycle and returns one 128-bit reduced product
// per word. The 256-bit carry-less product is built by a chain of eight
// cells, each adding the partial products of one 8-bit slice of each half
// of B; two fold stages then reduce it by 0xc200000000000000. The pipe has
// ten register stages: the eight cells, then the two fold registers of the
// reducer. Throughput is one word per cycle; the whole pipe advances
// together and holds while the output is stalled.
// The block keeps no state between words.
`timescale 1ns / 1ps
`include "gf128_clmul_multiply_reduce_core_defines.svh"
module gf128_clmul_multiply_reduce_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gcm_in_if.sink    i_in,
    gcm_out_if.source o_out
);
    import gcm_pkg::*;

    // Advance the whole pipe unless the last stage holds an untaken word.
    logic w_adv;
    logic  w_vld [NumCells+1];
    t_lane w_al [NumCells+1], w_ah [NumCells+1], w_bl [NumCells+1], w_bh [NumCells+1];
    t_wide w_p0 [NumCells+1], w_pm [NumCells+1], w_p3 [NumCells+1];
    t_wide w_res;

    assign w_adv = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_vld[0] = i_in.valid;
    assign w_al[0]  = i_in.a_low;
    assign w_ah[0]  = i_in.a_high;
    assign w_bl[0]  = i_in.b_low;
    assign w_bh[0]  = i_in.b_high;
    assign w_p0[0]  = '0;
    assign w_pm[0]  = '0;
    assign w_p3[0]  = '0;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        gcm_cell #(.CellIdx(g)) u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (w_adv),
            .i_vld (w_vld[g]),
            .i_al (w_al[g]), .i_ah (w_ah[g]), .i_bl (w_bl[g]), .i_bh (w_bh[g]),
            .i_p0 (w_p0[g]), .i_pm (w_pm[g]), .i_p3 (w_p3[g]),
            .o_vld (w_vld[g+1]),
            .o_al (w_al[g+1]), .o_ah (w_ah[g+1]), .o_bl (w_bl[g+1]), .o_bh (w_bh[g+1]),
            .o_p0 (w_p0[g+1]), .o_pm (w_pm[g+1]), .o_p3 (w_p3[g+1])
        );
    end

    // Fold the upper half twice and merge in the lower half.
    gcm_reduce u_reduce (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (w_adv),
        .i_vld (w_vld[NumCells]),
        .i_p0 (w_p0[NumCells]), .i_pm (w_pm[NumCells]), .i_p3 (w_p3[NumCells]),
        .o_vld (o_out.valid), .o_res (w_res)
    );

    assign o_out.product_low  = w_res[63:0];
    assign o_out.product_high = w_res[127:64];

    `GCM_ASSERT(a_stall_holds, i_clk, i_rst_n,
        (o_out.valid && !o_out.ready) |=> $stable(w_res) && o_out.valid,
        "stalled result changed")
    `GCM_ASSERT(a_ready_tracks, i_clk, i_rst_n,
        i_in.ready == (!o_out.valid || o_out.ready),
        "input ready does not follow output stall")
    `GCM_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out.valid,
        "output valid after reset")
endmodule

>>> rtl/core/gcm_cell.sv
// ----------------------------------------------------------------------------
// gcm_cell
// One stage of the multiplier chain: adds the partial products of one 8-bit slice of each B lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gcm_cell #(
    parameter int unsigned CellIdx = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_vld,
    input  gcm_pkg::t_lane       i_al, i_ah, i_bl, i_bh,
    input  gcm_pkg::t_wide       i_p0, i_pm, i_p3,
    output logic                 o_vld,
    output gcm_pkg::t_lane       o_al, o_ah, o_bl, o_bh,
    output gcm_pkg::t_wide       o_p0, o_pm, o_p3
);
    import gcm_pkg::*;
    localparam logic [6:0] Off = 7'(CellIdx * BitsPerCell);

    logic [7:0] w_bl, w_bh;
    assign w_bl = i_bl[CellIdx*BitsPerCell +: BitsPerCell];
    assign w_bh = i_bh[CellIdx*BitsPerCell +: BitsPerCell];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_al <= i_al;
            o_ah <= i_ah;
            o_bl <= i_bl;
            o_bh <= i_bh;
            o_p0 <= i_p0 ^ clmul_slice(i_al, w_bl, Off);
            o_pm <= i_pm ^ clmul_slice(i_al, w_bh, Off) ^ clmul_slice(i_ah, w_bl, Off);
            o_p3 <= i_p3 ^ clmul_slice(i_ah, w_bh, Off);
        end
    end
endmodule

>>> rtl/core/gcm_reduce.sv
// ----------------------------------------------------------------------------
// gcm_reduce
// Two registered fold steps that bring the 256-bit product to 128 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gcm_reduce (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  gcm_pkg::t_wide i_p0, i_pm, i_p3,
    output logic           o_vld,
    output gcm_pkg::t_wide o_res
);
    import gcm_pkg::*;
    logic  r_vld1;
    t_wide r_low, r_t;
    t_wide w_low, w_high, w_m1, w_m2;

    assign w_low  = i_p0 ^ {i_pm[63:0], 64'd0};
    assign w_high = i_p3 ^ {64'd0, i_pm[127:64]};
    assign w_m1   = clmul_fold(w_high[127:64]);
    assign w_m2   = clmul_fold(r_t[63:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_low <= w_low;
            r_t   <= {w_m1[127:64] ^ w_high[63:0], w_m1[63:0] ^ w_high[127:64]};
            o_res <= {w_m2[127:64] ^ r_t[63:0] ^ r_low[127:64],
                      w_m2[63:0] ^ r_t[127:64] ^ r_low[63:0]};
        end
    end
endmodule
